/* src/wamm_pkg.sv */
// shared types, constants and sequencer states for the windowed average / min / max block
// no dependencies; every other source file imports this package
package wamm_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int CFG_BITS         = 5;
  localparam int WINDOW_DEPTH_DEF = 16;

  localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RST = CFG_BITS'(16);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CFG_BITS-1:0]           cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_LOAD,
    ST_DIVIDE,
    ST_FINISH
  } wamm_state_e;

endpackage

/* src/wamm_cfg_if.sv */
// configuration write channel: valid/ready plus the window size
// depends on wamm_pkg
interface wamm_cfg_if import wamm_pkg::*; ();
  logic valid;
  logic ready;
  cfg_t window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

/* src/wamm_in_if.sv */
// sample input channel: valid/ready plus one signed sample
// depends on wamm_pkg
interface wamm_in_if import wamm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

/* src/wamm_out_if.sv */
// result channel: valid/ready plus sample, window average, maximum and minimum
// depends on wamm_pkg
interface wamm_out_if import wamm_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t current_value;
  sample_t running_average;
  sample_t maximum_value;
  sample_t minimum_value;

  modport source (output valid, output current_value, output running_average,
                  output maximum_value, output minimum_value, input ready);
  modport sink   (input valid, input current_value, input running_average,
                  input maximum_value, input minimum_value, output ready);
endinterface

/* src/windowed_average_min_max.sv */
// a sample goes through states READ, UPDATE, LOAD, DIVIDE, FINISH, then its result is registered
// a new sample is accepted only in ST_IDLE, after the previous one has left ST_FINISH
// the next sample is taken while a finished result still waits in the output register
// reset (rst_ni low, async): empty window, zero sum, window size 16, no min/max seen
// the sample ring is not cleared; a value read from it is only used once its slot has been written
// depends on wamm_pkg and the wamm_cfg_if, wamm_in_if and wamm_out_if interfaces
module windowed_average_min_max import wamm_pkg::*; #(
  parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wamm_cfg_if.sink    cfg_i,
  wamm_in_if.sink     in_i,
  wamm_out_if.source  out_o
);

  localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
  localparam int BIT_W = $clog2(SUM_W);

  wamm_state_e state_q, state_d;

  logic in_rdy, cfg_rdy, out_load;
  logic out_free;

  // window state
  cfg_t                    window_size_q;
  logic [CNT_W-1:0]        fill_q;
  logic [IDX_W-1:0]        oldest_q;
  logic signed [SUM_W-1:0] sum_q;
  logic                    seen_q;
  sample_t                 max_q, min_q;

  // per-item working registers
  sample_t          sample_q;
  sample_t          old_q;
  logic [IDX_W-1:0] slot_q;
  logic             full_q;
  logic [CNT_W-1:0] win_q;
  logic [SUM_W-1:0] quo_q;
  logic [CNT_W-1:0] rem_q;
  logic             neg_q;
  logic [BIT_W-1:0] bit_cnt_q;

  sample_t ring_q [WINDOW_DEPTH];

  logic                 out_vld_q;
  sample_t              out_cur_q, out_avg_q, out_max_q, out_min_q;

  logic [CNT_W-1:0]     win_eff;
  logic [CNT_W:0]       trial;
  logic [SUM_W-1:0]     avg_full;
  logic [CNT_W-1:0]     slot_inc;

  // saturate the programmed size to 1..WINDOW_DEPTH
  always_comb begin
    if (window_size_q == '0) begin
      win_eff = CNT_W'(1);
    end else if (32'(window_size_q) > WINDOW_DEPTH) begin
      win_eff = CNT_W'(WINDOW_DEPTH);
    end else begin
      win_eff = CNT_W'(window_size_q);
    end
  end

  assign out_free = !out_vld_q || out_o.ready;
  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign avg_full = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d  = state_q;
    in_rdy   = 1'b0;
    cfg_rdy  = 1'b0;
    out_load = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cfg_rdy = 1'b1;
        in_rdy  = !cfg_i.valid;
        if (in_i.valid && in_rdy) begin
          state_d = ST_READ;
        end
      end
      ST_READ:   state_d = ST_UPDATE;
      ST_UPDATE: state_d = ST_LOAD;
      ST_LOAD:   state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (bit_cnt_q == '0) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_i.ready  = in_rdy;
  assign cfg_i.ready = cfg_rdy;

  // sample ring, registered read of the slot about to be replaced
  always_ff @(posedge clk_i) begin
    if (state_q == ST_UPDATE) begin
      ring_q[slot_q] <= sample_q;
    end
    if (state_q == ST_READ) begin
      old_q <= ring_q[slot_q];
    end
  end

  // window size write, window, sum and extreme tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= WINDOW_SIZE_RST;
      fill_q        <= '0;
      oldest_q      <= '0;
      sum_q         <= '0;
      seen_q        <= 1'b0;
      max_q         <= '0;
      min_q         <= '0;
    end else if (cfg_i.valid && cfg_rdy) begin
      window_size_q <= cfg_i.window_size;
      fill_q        <= '0;
      oldest_q      <= '0;
      sum_q         <= '0;
    end else if (state_q == ST_UPDATE) begin
      sum_q <= sum_q - (full_q ? SUM_W'(old_q) : SUM_W'(0)) + SUM_W'(sample_q);
      if (full_q) begin
        oldest_q <= (slot_inc == win_q) ? '0 : slot_q + IDX_W'(1);
      end else begin
        fill_q <= fill_q + CNT_W'(1);
      end
      if (!seen_q || sample_q > max_q) begin
        max_q <= sample_q;
      end
      if (!seen_q || sample_q < min_q) begin
        min_q <= sample_q;
      end
      seen_q <= 1'b1;
    end
  end

  // item latch and restoring divider, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (in_i.valid && in_rdy) begin
          sample_q <= in_i.sample;
          win_q    <= win_eff;
          full_q   <= (fill_q >= win_eff);
          slot_q   <= (fill_q >= win_eff) ? oldest_q : fill_q[IDX_W-1:0];
        end
      end
      ST_LOAD: begin
        neg_q     <= sum_q[SUM_W-1];
        quo_q     <= sum_q[SUM_W-1] ? $unsigned(-sum_q) : $unsigned(sum_q);
        rem_q     <= '0;
        bit_cnt_q <= BIT_W'(SUM_W - 1);
      end
      ST_DIVIDE: begin
        bit_cnt_q <= bit_cnt_q - BIT_W'(1);
        if (trial >= {1'b0, fill_q}) begin
          rem_q <= CNT_W'(trial - {1'b0, fill_q});
          quo_q <= {quo_q[SUM_W-2:0], 1'b1};
        end else begin
          rem_q <= trial[CNT_W-1:0];
          quo_q <= {quo_q[SUM_W-2:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_cur_q <= sample_q;
      out_avg_q <= avg_full[SAMPLE_BITS-1:0];
      out_max_q <= max_q;
      out_min_q <= min_q;
    end
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.current_value   = out_cur_q;
  assign out_o.running_average = out_avg_q;
  assign out_o.maximum_value   = out_max_q;
  assign out_o.minimum_value   = out_min_q;

endmodule

/* src/wamm_checker.sv */
// port-level checks for windowed_average_min_max, attached by bind
// depends on wamm_pkg and the top level's interface ports
module wamm_checker import wamm_pkg::*; (
  input logic    clk_i,
  input logic    rst_ni,
  input logic    in_valid_i,
  input logic    in_ready_i,
  input logic    out_valid_i,
  input logic    out_ready_i,
  input sample_t cur_i,
  input sample_t avg_i,
  input sample_t max_i,
  input sample_t min_i
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cur_i) && $stable(avg_i)
      && $stable(max_i) && $stable(min_i))
    else $error("stalled result changed");

  // the block is busy right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input taken while busy");

  // the sample lies between all-time minimum and maximum
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (min_i <= cur_i) && (cur_i <= max_i))
    else $error("sample outside min/max");

  // the window average cannot leave the all-time range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (min_i <= avg_i) && (avg_i <= max_i))
    else $error("average outside min/max");

endmodule

bind windowed_average_min_max wamm_checker u_wamm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cur_i       (out_o.current_value),
  .avg_i       (out_o.running_average),
  .max_i       (out_o.maximum_value),
  .min_i       (out_o.minimum_value)
);
